>>> rtl/core/rudc_pkg.sv
// ----------------------------------------------------------------------------
// rudc_pkg
// Shared types and fixed-point constants of the radial undistortion
// coordinate mapper.
// ----------------------------------------------------------------------------
package rudc_pkg;

    // field and datapath widths
    localparam int PIX_W     = 13;  // pixel coordinate
    localparam int DIM_W     = 14;  // image dimension register
    localparam int OFF_W     = 15;  // doubled, centered offset (signed)
    localparam int SQ_W      = 28;  // offset squared
    localparam int SUM_W     = 29;  // sum of squares
    localparam int IFS_W     = 32;  // 1/f^2 register
    localparam int R2_W      = 43;  // r^2, Q24
    localparam int R2_LO_W   = 32;
    localparam int R2_HI_W   = R2_W - R2_LO_W;
    localparam int R2SQ_W    = 62;  // r^4, Q24
    localparam int R2SQ_LO_W = 31;
    localparam int KMAG_W    = 32;  // coefficient magnitude
    localparam int T1_W      = 51;  // |k1|*r^2, Q24
    localparam int T2_W      = 62;  // |k2|*r^4, Q24, saturated
    localparam int FAC_W     = 42;  // scale factor, Q24, signed, clamped
    localparam int SUMF_W    = 64;  // factor sum before clamp
    localparam int Q_SH      = 24;  // Q24 fraction bits
    localparam int FRAC_OUT_W = 16;

    // APB map
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INV_FOCAL_SQ = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RADIAL_K1    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RADIAL_K2    = 3'd4;

    // register reset values
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 14'd640;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 14'd480;
    localparam logic [IFS_W-1:0] RST_INV_FOCAL_SQ = 32'd4194304;

    // fixed-point constants
    localparam logic signed [SUMF_W-1:0] ONE_Q24   = 64'sh0000_0000_0100_0000;
    localparam logic signed [SUMF_W-1:0] FAC_CAP   = 64'sh0000_0100_0000_0000;
    localparam logic signed [FAC_W-1:0]  FAC_ONE   = 42'sh000_0100_0000;
    localparam logic signed [FAC_W-1:0]  FAC_MAX   = 42'sh100_0000_0000;
    localparam logic [T2_W-1:0]          TERM_CAP  = 62'h2000_0000_0000_0000;

    // input request
    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } t_pix_req;

    // output result
    typedef struct packed {
        logic [PIX_W-1:0]      src_x_int;
        logic [FRAC_OUT_W-1:0] src_x_frac;
        logic [PIX_W-1:0]      src_y_int;
        logic [FRAC_OUT_W-1:0] src_y_frac;
        logic                  inside_res;
    } t_map_rsp;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic [DIM_W-1:0]  width_eff;
        logic [DIM_W-1:0]  height_eff;
        logic [IFS_W-1:0]  inv_focal_sq;
        logic [KMAG_W-1:0] k1_mag;
        logic              k1_neg;
        logic [KMAG_W-1:0] k2_mag;
        logic              k2_neg;
    } t_cfg;

    // radius stage output
    typedef struct packed {
        logic signed [OFF_W-1:0] dx;
        logic signed [OFF_W-1:0] dy;
        logic [R2_W-1:0]         r2;
    } t_rad;

    // factor stage output
    typedef struct packed {
        logic signed [OFF_W-1:0] dx;
        logic signed [OFF_W-1:0] dy;
        logic signed [FAC_W-1:0] fac;
    } t_fac;

endpackage

>>> rtl/core/rudc_chan_if.sv
// ----------------------------------------------------------------------------
// rudc_chan_if
// Valid/ready channel carrying one payload per accepted cycle.
// ----------------------------------------------------------------------------
interface rudc_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/rudc_apb_regs.sv
// ----------------------------------------------------------------------------
// rudc_apb_regs
// APB register file: image size, 1/f^2 and the two radial coefficients.
// Presents clamped sizes and coefficient magnitudes to the datapath.
// ----------------------------------------------------------------------------
module rudc_apb_regs #(
    parameter int MAX_DIM = 8192
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rudc_pkg::APB_AW-1:0]  paddr,
    input  logic [rudc_pkg::APB_DW-1:0]  pwdata,
    output logic [rudc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output rudc_pkg::t_cfg               o_cfg
);

    localparam int MD_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (MD_W > rudc_pkg::DIM_W) ? MD_W : rudc_pkg::DIM_W;
    localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

    logic [rudc_pkg::DIM_W-1:0]  r_image_width;
    logic [rudc_pkg::DIM_W-1:0]  r_image_height;
    logic [rudc_pkg::IFS_W-1:0]  r_inv_focal_sq;
    logic [rudc_pkg::KMAG_W-1:0] r_radial_k1;
    logic [rudc_pkg::KMAG_W-1:0] r_radial_k2;

    logic                             wr_en;
    logic [rudc_pkg::REG_IDX_W-1:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[rudc_pkg::APB_AW-1:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= rudc_pkg::RST_IMAGE_WIDTH;
            r_image_height <= rudc_pkg::RST_IMAGE_HEIGHT;
            r_inv_focal_sq <= rudc_pkg::RST_INV_FOCAL_SQ;
            r_radial_k1    <= '0;
            r_radial_k2    <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                rudc_pkg::REG_IMAGE_WIDTH:  r_image_width  <= pwdata[rudc_pkg::DIM_W-1:0];
                rudc_pkg::REG_IMAGE_HEIGHT: r_image_height <= pwdata[rudc_pkg::DIM_W-1:0];
                rudc_pkg::REG_INV_FOCAL_SQ: r_inv_focal_sq <= pwdata;
                rudc_pkg::REG_RADIAL_K1:    r_radial_k1    <= pwdata;
                rudc_pkg::REG_RADIAL_K2:    r_radial_k2    <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            rudc_pkg::REG_IMAGE_WIDTH:  prdata = rudc_pkg::APB_DW'(r_image_width);
            rudc_pkg::REG_IMAGE_HEIGHT: prdata = rudc_pkg::APB_DW'(r_image_height);
            rudc_pkg::REG_INV_FOCAL_SQ: prdata = r_inv_focal_sq;
            rudc_pkg::REG_RADIAL_K1:    prdata = r_radial_k1;
            rudc_pkg::REG_RADIAL_K2:    prdata = r_radial_k2;
            default:                    prdata = '0;
        endcase
    end

    // effective values: sizes clamped to MAX_DIM, coefficients as sign/magnitude
    always_comb begin
        o_cfg.width_eff    = (CMP_W'(r_image_width) > MAX_DIM_C) ?
                             rudc_pkg::DIM_W'(MAX_DIM) : r_image_width;
        o_cfg.height_eff   = (CMP_W'(r_image_height) > MAX_DIM_C) ?
                             rudc_pkg::DIM_W'(MAX_DIM) : r_image_height;
        o_cfg.inv_focal_sq = r_inv_focal_sq;
        o_cfg.k1_neg       = r_radial_k1[rudc_pkg::KMAG_W-1];
        o_cfg.k1_mag       = o_cfg.k1_neg ? (~r_radial_k1 + 1'b1) : r_radial_k1;
        o_cfg.k2_neg       = r_radial_k2[rudc_pkg::KMAG_W-1];
        o_cfg.k2_mag       = o_cfg.k2_neg ? (~r_radial_k2 + 1'b1) : r_radial_k2;
    end

endmodule

>>> rtl/core/rudc_radius.sv
// ----------------------------------------------------------------------------
// rudc_radius
// Four-stage pipeline: centered doubled offsets, squares, sum, and
// r^2 = (dx^2 + dy^2) * inv_focal_sq >> 18 in Q24.
// ----------------------------------------------------------------------------
module rudc_radius (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rudc_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  rudc_pkg::t_pix_req i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output rudc_pkg::t_rad     o_data
);

    localparam int NS     = 4;
    localparam int PROD_W = rudc_pkg::SUM_W + rudc_pkg::IFS_W;
    localparam int R2_SH  = 40 - rudc_pkg::Q_SH + 2;  // (s4/4) * ifs / 2^40 in Q24

    logic [NS-1:0] r_v;
    logic [NS:0]   adv;

    logic signed [rudc_pkg::OFF_W-1:0] r_dx [NS];
    logic signed [rudc_pkg::OFF_W-1:0] r_dy [NS];
    logic [rudc_pkg::SQ_W-1:0]         r_dxsq;
    logic [rudc_pkg::SQ_W-1:0]         r_dysq;
    logic [rudc_pkg::SUM_W-1:0]        r_s4;
    logic [rudc_pkg::R2_W-1:0]         r_r2;

    logic signed [rudc_pkg::OFF_W-1:0]   n_dx;
    logic signed [rudc_pkg::OFF_W-1:0]   n_dy;
    logic signed [2*rudc_pkg::OFF_W-1:0] n_dxsq;
    logic signed [2*rudc_pkg::OFF_W-1:0] n_dysq;
    logic [PROD_W-1:0]                   n_prod;

    // stage advance: a stage loads when empty or when its successor moves
    always_comb begin
        adv[NS] = i_ready;
        adv[3]  = !r_v[3] || adv[4];
        adv[2]  = !r_v[2] || adv[3];
        adv[1]  = !r_v[1] || adv[2];
        adv[0]  = !r_v[0] || adv[1];
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[NS-1];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            if (adv[1]) r_v[1] <= r_v[0];
            if (adv[2]) r_v[2] <= r_v[1];
            if (adv[3]) r_v[3] <= r_v[2];
        end
    end

    // datapath
    assign n_dx   = $signed({1'b0, i_data.pixel_x, 1'b0}) - $signed({1'b0, i_cfg.width_eff});
    assign n_dy   = $signed({1'b0, i_data.pixel_y, 1'b0}) - $signed({1'b0, i_cfg.height_eff});
    assign n_dxsq = r_dx[0] * r_dx[0];
    assign n_dysq = r_dy[0] * r_dy[0];
    assign n_prod = PROD_W'(r_s4) * PROD_W'(i_cfg.inv_focal_sq);

    always_ff @(posedge i_clk) begin
        // centered offsets
        if (adv[0]) begin
            r_dx[0] <= n_dx;
            r_dy[0] <= n_dy;
        end
        // squares
        if (adv[1]) begin
            r_dx[1] <= r_dx[0];
            r_dy[1] <= r_dy[0];
            r_dxsq  <= n_dxsq[rudc_pkg::SQ_W-1:0];
            r_dysq  <= n_dysq[rudc_pkg::SQ_W-1:0];
        end
        // sum of squares
        if (adv[2]) begin
            r_dx[2] <= r_dx[1];
            r_dy[2] <= r_dy[1];
            r_s4    <= rudc_pkg::SUM_W'(r_dxsq) + rudc_pkg::SUM_W'(r_dysq);
        end
        // scale by 1/f^2
        if (adv[3]) begin
            r_dx[3] <= r_dx[2];
            r_dy[3] <= r_dy[2];
            r_r2    <= n_prod[R2_SH +: rudc_pkg::R2_W];
        end
    end

    assign o_data.dx = r_dx[NS-1];
    assign o_data.dy = r_dy[NS-1];
    assign o_data.r2 = r_r2;

`ifndef NO_ASSERTIONS
    // zero 1/f^2 gives a zero radius
    a_r2_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] && (i_cfg.inv_focal_sq == '0) |-> (r_r2 == '0))
        else $error("r2 nonzero with zero inv_focal_sq");
`endif

endmodule

>>> rtl/core/rudc_factor.sv
// ----------------------------------------------------------------------------
// rudc_factor
// Five-stage pipeline: r^4 and k1*r^2 partial products, their sums,
// k2*r^4 partial products, saturated k2 term, then 1 + k1 r^2 + k2 r^4
// clamped to +-65536.0 (Q24).
// ----------------------------------------------------------------------------
module rudc_factor (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rudc_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  rudc_pkg::t_rad i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output rudc_pkg::t_fac o_data
);

    localparam int NS      = 5;
    localparam int LL_W    = 2 * rudc_pkg::R2_LO_W;
    localparam int LH_W    = rudc_pkg::R2_LO_W + rudc_pkg::R2_HI_W;
    localparam int HH_W    = 2 * rudc_pkg::R2_HI_W;
    localparam int SQF_W   = 2 * rudc_pkg::R2_W;
    localparam int K1L_W   = rudc_pkg::KMAG_W + rudc_pkg::R2_LO_W;
    localparam int K1H_W   = rudc_pkg::KMAG_W + rudc_pkg::R2_HI_W;
    localparam int T1F_W   = rudc_pkg::KMAG_W + rudc_pkg::R2_W;
    localparam int K2P_W   = rudc_pkg::KMAG_W + rudc_pkg::R2SQ_LO_W;
    localparam int R2SQ_HI_W = rudc_pkg::R2SQ_W - rudc_pkg::R2SQ_LO_W;
    localparam int T2F_W   = rudc_pkg::KMAG_W + rudc_pkg::R2SQ_W;
    localparam int T2R_W   = T2F_W - rudc_pkg::Q_SH;
    localparam int T1S_W   = rudc_pkg::T1_W + 1;
    localparam int SW      = rudc_pkg::SUMF_W;

    logic [NS-1:0] r_v;
    logic [NS:0]   adv;

    logic signed [rudc_pkg::OFF_W-1:0] r_dx [NS];
    logic signed [rudc_pkg::OFF_W-1:0] r_dy [NS];

    logic [LL_W-1:0]              r_pll;
    logic [LH_W-1:0]              r_plh;
    logic [HH_W-1:0]              r_phh;
    logic [K1L_W-1:0]             r_pk1l;
    logic [K1H_W-1:0]             r_pk1h;
    logic [rudc_pkg::R2SQ_W-1:0]  r_r2sq;
    logic [rudc_pkg::T1_W-1:0]    r_t1mag;
    logic [K2P_W-1:0]             r_pk2l;
    logic [K2P_W-1:0]             r_pk2h;
    logic signed [T1S_W-1:0]      r_t1s [2];
    logic [rudc_pkg::T2_W-1:0]    r_t2mag;
    logic signed [rudc_pkg::FAC_W-1:0] r_fac;

    logic [rudc_pkg::R2_LO_W-1:0] r2_lo;
    logic [rudc_pkg::R2_HI_W-1:0] r2_hi;
    logic [SQF_W-1:0]             n_sq;
    logic [T1F_W-1:0]             n_t1;
    logic signed [T1S_W-1:0]      n_t1s;
    logic [T2F_W-1:0]             n_t2;
    logic [T2R_W-1:0]             n_t2raw;
    logic [rudc_pkg::T2_W-1:0]    n_t2mag;
    logic signed [SW-1:0]         n_t1e;
    logic signed [SW-1:0]         n_t2e;
    logic signed [SW-1:0]         n_sum;
    logic signed [rudc_pkg::FAC_W-1:0] n_fac;

    // stage advance
    always_comb begin
        adv[NS] = i_ready;
        adv[4]  = !r_v[4] || adv[5];
        adv[3]  = !r_v[3] || adv[4];
        adv[2]  = !r_v[2] || adv[3];
        adv[1]  = !r_v[1] || adv[2];
        adv[0]  = !r_v[0] || adv[1];
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            if (adv[1]) r_v[1] <= r_v[0];
            if (adv[2]) r_v[2] <= r_v[1];
            if (adv[3]) r_v[3] <= r_v[2];
            if (adv[4]) r_v[4] <= r_v[3];
        end
    end

    assign r2_lo = i_data.r2[rudc_pkg::R2_LO_W-1:0];
    assign r2_hi = i_data.r2[rudc_pkg::R2_W-1:rudc_pkg::R2_LO_W];

    // partial-product sums: r^4 and |k1|*r^2, both floored to Q24
    assign n_sq = (SQF_W'(r_phh) << (2 * rudc_pkg::R2_LO_W))
                + (SQF_W'(r_plh) << (rudc_pkg::R2_LO_W + 1))
                + SQF_W'(r_pll);
    assign n_t1 = (T1F_W'(r_pk1h) << rudc_pkg::R2_LO_W) + T1F_W'(r_pk1l);

    // k1 term sign applied after truncating the magnitude
    assign n_t1s = i_cfg.k1_neg ? -$signed({1'b0, r_t1mag}) : $signed({1'b0, r_t1mag});

    // |k2|*r^4 floored, saturated at 2^61
    assign n_t2    = (T2F_W'(r_pk2h) << rudc_pkg::R2SQ_LO_W) + T2F_W'(r_pk2l);
    assign n_t2raw = n_t2[T2F_W-1:rudc_pkg::Q_SH];
    assign n_t2mag = (n_t2raw > T2R_W'(rudc_pkg::TERM_CAP)) ?
                     rudc_pkg::TERM_CAP : n_t2raw[rudc_pkg::T2_W-1:0];

    // factor sum and clamp
    assign n_t1e = {{(SW - T1S_W){r_t1s[1][T1S_W-1]}}, r_t1s[1]};
    assign n_t2e = $signed({{(SW - rudc_pkg::T2_W){1'b0}}, r_t2mag});
    assign n_sum = rudc_pkg::ONE_Q24 + n_t1e + (i_cfg.k2_neg ? -n_t2e : n_t2e);

    always_comb begin
        if (n_sum > rudc_pkg::FAC_CAP) begin
            n_fac = rudc_pkg::FAC_MAX;
        end else if (n_sum < -rudc_pkg::FAC_CAP) begin
            n_fac = -rudc_pkg::FAC_MAX;
        end else begin
            n_fac = n_sum[rudc_pkg::FAC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        // partial products of r^2*r^2 and |k1|*r^2
        if (adv[0]) begin
            r_dx[0] <= i_data.dx;
            r_dy[0] <= i_data.dy;
            r_pll   <= LL_W'(r2_lo) * LL_W'(r2_lo);
            r_plh   <= LH_W'(r2_lo) * LH_W'(r2_hi);
            r_phh   <= HH_W'(r2_hi) * HH_W'(r2_hi);
            r_pk1l  <= K1L_W'(i_cfg.k1_mag) * K1L_W'(r2_lo);
            r_pk1h  <= K1H_W'(i_cfg.k1_mag) * K1H_W'(r2_hi);
        end
        // combine partial products
        if (adv[1]) begin
            r_dx[1] <= r_dx[0];
            r_dy[1] <= r_dy[0];
            r_r2sq  <= n_sq[SQF_W-1:rudc_pkg::Q_SH];
            r_t1mag <= n_t1[T1F_W-1:rudc_pkg::Q_SH];
        end
        // partial products of |k2|*r^4
        if (adv[2]) begin
            r_dx[2]  <= r_dx[1];
            r_dy[2]  <= r_dy[1];
            r_pk2l   <= K2P_W'(i_cfg.k2_mag) * K2P_W'(r_r2sq[rudc_pkg::R2SQ_LO_W-1:0]);
            r_pk2h   <= K2P_W'(i_cfg.k2_mag)
                      * K2P_W'(r_r2sq[rudc_pkg::R2SQ_W-1 -: R2SQ_HI_W]);
            r_t1s[0] <= n_t1s;
        end
        // saturated k2 term
        if (adv[3]) begin
            r_dx[3]  <= r_dx[2];
            r_dy[3]  <= r_dy[2];
            r_t2mag  <= n_t2mag;
            r_t1s[1] <= r_t1s[0];
        end
        // clamped factor
        if (adv[4]) begin
            r_dx[4] <= r_dx[3];
            r_dy[4] <= r_dy[3];
            r_fac   <= n_fac;
        end
    end

    assign o_data.dx  = r_dx[NS-1];
    assign o_data.dy  = r_dy[NS-1];
    assign o_data.fac = r_fac;

`ifndef NO_ASSERTIONS
    // factor never leaves the clamp window
    a_fac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] |-> (r_fac <= rudc_pkg::FAC_MAX) && (r_fac >= -rudc_pkg::FAC_MAX))
        else $error("factor outside clamp range");

    // zero coefficients give unity scale
    a_fac_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] && (i_cfg.k1_mag == '0) && (i_cfg.k2_mag == '0)
        |-> (r_fac == rudc_pkg::FAC_ONE))
        else $error("factor not one with zero coefficients");
`endif

endmodule

>>> rtl/core/rudc_remap.sv
// ----------------------------------------------------------------------------
// rudc_remap
// Three-stage pipeline: offset times factor, recentering into a
// FRAC_BITS fixed-point coordinate, then range check and output register.
// ----------------------------------------------------------------------------
module rudc_remap #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rudc_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  rudc_pkg::t_fac     i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output rudc_pkg::t_map_rsp o_data
);

    localparam int NS     = 3;
    localparam int PROD_W = rudc_pkg::OFF_W + rudc_pkg::FAC_W;
    localparam int SH     = rudc_pkg::Q_SH + 1 - FRAC_BITS;
    localparam int MW     = PROD_W - SH + 1;
    localparam int CEN_PAD = MW - rudc_pkg::DIM_W - FRAC_BITS + 1;
    localparam int LIM_PAD = MW - rudc_pkg::OFF_W - FRAC_BITS;
    localparam int FF_W   = FRAC_BITS + rudc_pkg::FRAC_OUT_W;

    logic [NS-1:0] r_v;
    logic [NS:0]   adv;

    logic signed [PROD_W-1:0] r_prodx;
    logic signed [PROD_W-1:0] r_prody;
    logic signed [MW-1:0]     r_mx;
    logic signed [MW-1:0]     r_my;
    rudc_pkg::t_map_rsp       r_out;

    logic signed [PROD_W-1:0] n_dxe;
    logic signed [PROD_W-1:0] n_dye;
    logic signed [PROD_W-1:0] n_face;
    logic signed [PROD_W-1:0] n_qx;
    logic signed [PROD_W-1:0] n_qy;
    logic signed [MW-1:0]     cen_x;
    logic signed [MW-1:0]     cen_y;
    logic signed [rudc_pkg::OFF_W-1:0] wm1;
    logic signed [rudc_pkg::OFF_W-1:0] hm1;
    logic signed [MW-1:0]     lim_x;
    logic signed [MW-1:0]     lim_y;
    logic                     n_inside;
    logic [FF_W-1:0]          n_fx;
    logic [FF_W-1:0]          n_fy;
    rudc_pkg::t_map_rsp       n_out;

    // stage advance
    always_comb begin
        adv[NS] = i_ready;
        adv[2]  = !r_v[2] || adv[3];
        adv[1]  = !r_v[1] || adv[2];
        adv[0]  = !r_v[0] || adv[1];
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            if (adv[1]) r_v[1] <= r_v[0];
            if (adv[2]) r_v[2] <= r_v[1];
        end
    end

    // scaled offsets
    assign n_dxe  = {{(PROD_W - rudc_pkg::OFF_W){i_data.dx[rudc_pkg::OFF_W-1]}}, i_data.dx};
    assign n_dye  = {{(PROD_W - rudc_pkg::OFF_W){i_data.dy[rudc_pkg::OFF_W-1]}}, i_data.dy};
    assign n_face = {{(PROD_W - rudc_pkg::FAC_W){i_data.fac[rudc_pkg::FAC_W-1]}}, i_data.fac};

    // floor to FRAC_BITS and add the center back
    assign n_qx  = r_prodx >>> SH;
    assign n_qy  = r_prody >>> SH;
    assign cen_x = $signed({{CEN_PAD{1'b0}}, i_cfg.width_eff, {(FRAC_BITS-1){1'b0}}});
    assign cen_y = $signed({{CEN_PAD{1'b0}}, i_cfg.height_eff, {(FRAC_BITS-1){1'b0}}});

    // interpolable area: [0, dim-1) on both axes
    assign wm1   = $signed({1'b0, i_cfg.width_eff}) - 15'sd1;
    assign hm1   = $signed({1'b0, i_cfg.height_eff}) - 15'sd1;
    assign lim_x = $signed({{LIM_PAD{wm1[rudc_pkg::OFF_W-1]}}, wm1, {FRAC_BITS{1'b0}}});
    assign lim_y = $signed({{LIM_PAD{hm1[rudc_pkg::OFF_W-1]}}, hm1, {FRAC_BITS{1'b0}}});

    assign n_inside = !r_mx[MW-1] && (r_mx < lim_x) && !r_my[MW-1] && (r_my < lim_y);

    // fraction moved to 16 bits
    assign n_fx = {r_mx[FRAC_BITS-1:0], {rudc_pkg::FRAC_OUT_W{1'b0}}};
    assign n_fy = {r_my[FRAC_BITS-1:0], {rudc_pkg::FRAC_OUT_W{1'b0}}};

    // outside points report all zeros
    always_comb begin
        n_out = '0;
        if (n_inside) begin
            n_out.src_x_int  = r_mx[FRAC_BITS +: rudc_pkg::PIX_W];
            n_out.src_x_frac = n_fx[FF_W-1 -: rudc_pkg::FRAC_OUT_W];
            n_out.src_y_int  = r_my[FRAC_BITS +: rudc_pkg::PIX_W];
            n_out.src_y_frac = n_fy[FF_W-1 -: rudc_pkg::FRAC_OUT_W];
            n_out.inside_res = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_prodx <= n_dxe * n_face;
            r_prody <= n_dye * n_face;
        end
        if (adv[1]) begin
            r_mx <= $signed(n_qx[MW-1:0]) + cen_x;
            r_my <= $signed(n_qy[MW-1:0]) + cen_y;
        end
        if (adv[2]) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

`ifndef NO_ASSERTIONS
    // an outside point carries no coordinates
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.inside_res |->
            (o_data.src_x_int == '0) && (o_data.src_x_frac == '0)
            && (o_data.src_y_int == '0) && (o_data.src_y_frac == '0))
        else $error("outside point with nonzero coordinates");

    // a recentered item moving forward lands in the output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[1] && adv[2] |=> o_valid)
        else $error("item lost entering output register");
`endif

endmodule

>>> rtl/core/radial_undistort_coord_map_unit.sv
// ----------------------------------------------------------------------------
// radial_undistort_coord_map_unit
// A request accepted on i_pix passes 4 radius stages, 5 factor stages and
// 2 remap stages plus the output register. Throughput: one request per
// cycle unless o_map stalls; the multiplier stages set the depth.
// i_pix.ready falls only when every stage holds an item and o_map stalls.
// Reset (synchronous, active low) empties the pipeline and loads the
// registers with their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module radial_undistort_coord_map_unit #(
    parameter int MAX_DIM   = 8192,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rudc_chan_if.sink                   i_pix,
    rudc_chan_if.source                 o_map,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rudc_pkg::APB_AW-1:0] paddr,
    input  logic [rudc_pkg::APB_DW-1:0] pwdata,
    output logic [rudc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    rudc_pkg::t_cfg     cfg;
    rudc_pkg::t_rad     rad_data;
    rudc_pkg::t_fac     fac_data;
    rudc_pkg::t_map_rsp map_data;
    logic               rad_valid;
    logic               rad_ready;
    logic               fac_valid;
    logic               fac_ready;
    logic               map_valid;

    // configuration registers
    rudc_apb_regs #(
        .MAX_DIM (MAX_DIM)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // r^2
    rudc_radius u_radius (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_data  (i_pix.payload),
        .o_valid (rad_valid),
        .i_ready (rad_ready),
        .o_data  (rad_data)
    );

    // radial scale factor
    rudc_factor u_factor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (rad_valid),
        .o_ready (rad_ready),
        .i_data  (rad_data),
        .o_valid (fac_valid),
        .i_ready (fac_ready),
        .o_data  (fac_data)
    );

    // source coordinate and range check
    rudc_remap #(
        .FRAC_BITS (FRAC_BITS)
    ) u_remap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (fac_valid),
        .o_ready (fac_ready),
        .i_data  (fac_data),
        .o_valid (map_valid),
        .i_ready (o_map.ready),
        .o_data  (map_data)
    );

    assign o_map.valid   = map_valid;
    assign o_map.payload = map_data;

endmodule
